FILE: rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared widths, payload structs and defaults of the segment intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned DIFF_W        = 33;
  localparam int unsigned PROD_W        = 66;
  localparam int unsigned CROSS_W       = 67;
  localparam int unsigned TOL_W         = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  // start point and direction of the first segment, carried to the point stage
  typedef struct packed {
    logic signed [COORD_W-1:0] p0x;
    logic signed [COORD_W-1:0] p0y;
    logic signed [DIFF_W-1:0]  l1x;
    logic signed [DIFF_W-1:0]  l1y;
  } geo_t;

  typedef struct packed {
    logic t_neg;
    logic u_neg;
    logic miss;
  } sign_t;

  // handshake between neighboring stages
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

`default_nettype wire

FILE: rtl/ssi_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Differences, cross products, magnitudes and quotient range pre-check.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_front import ssi_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned QB        = 18,
  parameter int unsigned NW        = CROSS_W + FRAC_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output      logic                      ready_o,
  input  wire logic [8*COORD_W-1:0]      coords_i,
  output      hs_t                       out_o,
  input  wire logic                      ready_i,
  output      geo_t                      geo_o,
  output      sign_t                     sign_o,
  output      logic [CROSS_W-1:0]        den_o,
  output      logic [NW-1:0]             num_t_o,
  output      logic [NW-1:0]             num_u_o
);

  localparam int unsigned CW = CROSS_W + QB;

  logic [3:0] v_q;
  logic [3:0] rdy;

  assign rdy[3] = !v_q[3] || ready_i;
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  // stage A: differences
  logic signed [COORD_W-1:0] p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
  assign p0x = coords_i[0*COORD_W +: COORD_W];
  assign p0y = coords_i[1*COORD_W +: COORD_W];
  assign p1x = coords_i[2*COORD_W +: COORD_W];
  assign p1y = coords_i[3*COORD_W +: COORD_W];
  assign q0x = coords_i[4*COORD_W +: COORD_W];
  assign q0y = coords_i[5*COORD_W +: COORD_W];
  assign q1x = coords_i[6*COORD_W +: COORD_W];
  assign q1y = coords_i[7*COORD_W +: COORD_W];

  geo_t a_geo_q;
  logic signed [DIFF_W-1:0] l2x_q, l2y_q, wx_q, wy_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      a_geo_q.p0x <= p0x;
      a_geo_q.p0y <= p0y;
      a_geo_q.l1x <= DIFF_W'(p1x) - DIFF_W'(p0x);
      a_geo_q.l1y <= DIFF_W'(p1y) - DIFF_W'(p0y);
      l2x_q       <= DIFF_W'(q1x) - DIFF_W'(q0x);
      l2y_q       <= DIFF_W'(q1y) - DIFF_W'(q0y);
      wx_q        <= DIFF_W'(q0x) - DIFF_W'(p0x);
      wy_q        <= DIFF_W'(q0y) - DIFF_W'(p0y);
    end
  end

  // stage B: products
  geo_t b_geo_q;
  logic signed [PROD_W-1:0] a1_q, a2_q, b1_q, b2_q, c1_q, c2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      b_geo_q <= a_geo_q;
      a1_q    <= PROD_W'(a_geo_q.l1x) * PROD_W'(l2y_q);
      a2_q    <= PROD_W'(a_geo_q.l1y) * PROD_W'(l2x_q);
      b1_q    <= PROD_W'(wx_q) * PROD_W'(l2y_q);
      b2_q    <= PROD_W'(wy_q) * PROD_W'(l2x_q);
      c1_q    <= PROD_W'(wx_q) * PROD_W'(a_geo_q.l1y);
      c2_q    <= PROD_W'(wy_q) * PROD_W'(a_geo_q.l1x);
    end
  end

  // stage C: cross products
  geo_t c_geo_q;
  logic signed [CROSS_W-1:0] den_q, tn_q, un_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      c_geo_q <= b_geo_q;
      den_q   <= CROSS_W'(a1_q) - CROSS_W'(a2_q);
      tn_q    <= CROSS_W'(b1_q) - CROSS_W'(b2_q);
      un_q    <= CROSS_W'(c1_q) - CROSS_W'(c2_q);
    end
  end

  // stage D: magnitudes, scaled numerators, out-of-range quotient check
  logic [CROSS_W-1:0] dm, tm, um;
  logic [NW-1:0]      nt, nu;
  logic [CW-1:0]      dlim;

  always_comb begin
    dm   = den_q[CROSS_W-1] ? CROSS_W'(-den_q) : CROSS_W'(den_q);
    tm   = tn_q[CROSS_W-1] ? CROSS_W'(-tn_q) : CROSS_W'(tn_q);
    um   = un_q[CROSS_W-1] ? CROSS_W'(-un_q) : CROSS_W'(un_q);
    nt   = NW'(tm) << FRAC_BITS;
    nu   = NW'(um) << FRAC_BITS;
    dlim = CW'(dm) << QB;
  end

  geo_t               d_geo_q;
  sign_t              d_sign_q;
  logic [CROSS_W-1:0] dm_q;
  logic [NW-1:0]      nt_q, nu_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      d_geo_q        <= c_geo_q;
      d_sign_q.t_neg <= tn_q[CROSS_W-1] ^ den_q[CROSS_W-1];
      d_sign_q.u_neg <= un_q[CROSS_W-1] ^ den_q[CROSS_W-1];
      d_sign_q.miss  <= (den_q == '0) || (CW'(nt) >= dlim) || (CW'(nu) >= dlim);
      dm_q           <= dm;
      nt_q           <= nt;
      nu_q           <= nu;
    end
  end

  assign out_o.valid = v_q[3];
  assign out_o.ready = rdy[3];
  assign geo_o       = d_geo_q;
  assign sign_o      = d_sign_q;
  assign den_o       = dm_q;
  assign num_t_o     = nt_q;
  assign num_u_o     = nu_q;

endmodule

`default_nettype wire

FILE: rtl/ssi_cell.sv
// ----------------------------------------------------------------------------
// Segment intersection divider cell
// Resolves one quotient bit of both parameters and passes the item on.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_cell import ssi_pkg::*; #(
  parameter int unsigned QB  = 18,
  parameter int unsigned NW  = 83,
  parameter int unsigned BIT = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output      logic               ready_o,
  input  wire geo_t               geo_i,
  input  wire sign_t              sign_i,
  input  wire logic [CROSS_W-1:0] den_i,
  input  wire logic [NW-1:0]      rem_t_i,
  input  wire logic [NW-1:0]      rem_u_i,
  input  wire logic [QB-1:0]      q_t_i,
  input  wire logic [QB-1:0]      q_u_i,
  output      logic               valid_o,
  input  wire logic               ready_i,
  output      geo_t               geo_o,
  output      sign_t              sign_o,
  output      logic [CROSS_W-1:0] den_o,
  output      logic [NW-1:0]      rem_t_o,
  output      logic [NW-1:0]      rem_u_o,
  output      logic [QB-1:0]      q_t_o,
  output      logic [QB-1:0]      q_u_o
);

  localparam int unsigned CW = CROSS_W + QB;

  logic          valid_q;
  logic [CW-1:0] dsh;
  logic          ge_t, ge_u;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_comb begin
    dsh  = CW'(den_i) << BIT;
    ge_t = CW'(rem_t_i) >= dsh;
    ge_u = CW'(rem_u_i) >= dsh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      geo_o   <= geo_i;
      sign_o  <= sign_i;
      den_o   <= den_i;
      rem_t_o <= ge_t ? NW'(rem_t_i - NW'(dsh)) : rem_t_i;
      rem_u_o <= ge_u ? NW'(rem_u_i - NW'(dsh)) : rem_u_i;
      q_t_o   <= q_t_i | (QB'(ge_t) << BIT);
      q_u_o   <= q_u_i | (QB'(ge_u) << BIT);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssi_back.sv
// ----------------------------------------------------------------------------
// Segment intersection back end
// Range test of both parameters, point products, shift and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_back import ssi_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned QB        = 18
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [TOL_W-1:0]          tol_i,
  input  wire logic                      valid_i,
  output      logic                      ready_o,
  input  wire geo_t                      geo_i,
  input  wire sign_t                     sign_i,
  input  wire logic [QB-1:0]             q_t_i,
  input  wire logic [QB-1:0]             q_u_i,
  output      logic                      valid_o,
  input  wire logic                      ready_i,
  output      logic                      hit_o,
  output      logic signed [COORD_W-1:0] cross_x_o,
  output      logic signed [COORD_W-1:0] cross_y_o
);

  localparam int unsigned SW   = QB + 2;
  localparam int unsigned PRW  = QB + 1 + DIFF_W;
  localparam int unsigned SUMW = PRW + 1;

  logic [1:0] v_q;
  logic [1:0] rdy;

  assign rdy[1]  = !v_q[1] || ready_i;
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = v_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  // stage E: signed parameters, range test, products
  logic signed [QB:0]   t_s, u_s;
  logic signed [SW-1:0] lowb, highb, t_w, u_w;
  logic                 in_range;

  always_comb begin
    t_s      = sign_i.t_neg ? -$signed({1'b0, q_t_i}) : $signed({1'b0, q_t_i});
    u_s      = sign_i.u_neg ? -$signed({1'b0, q_u_i}) : $signed({1'b0, q_u_i});
    t_w      = SW'(t_s);
    u_w      = SW'(u_s);
    lowb     = -$signed(SW'(tol_i));
    highb    = $signed((SW'(1) << FRAC_BITS) + SW'(tol_i));
    in_range = !sign_i.miss && (t_w >= lowb) && (t_w <= highb)
               && (u_w >= lowb) && (u_w <= highb);
  end

  logic                        hit_q;
  logic signed [COORD_W-1:0]   p0x_q, p0y_q;
  logic signed [PRW-1:0]       px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      hit_q <= in_range;
      p0x_q <= geo_i.p0x;
      p0y_q <= geo_i.p0y;
      px_q  <= PRW'(t_s) * PRW'(geo_i.l1x);
      py_q  <= PRW'(t_s) * PRW'(geo_i.l1y);
    end
  end

  // stage F: floor shift, add, saturate; zero the point on a miss
  logic signed [SUMW-1:0]    sx, sy;
  logic signed [COORD_W-1:0] cx, cy;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUMW-1:0] v);
    logic hi_same;
    hi_same = (v[SUMW-1:COORD_W-1] == '0) || (v[SUMW-1:COORD_W-1] == '1);
    if (hi_same) return v[COORD_W-1:0];
    return v[SUMW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  always_comb begin
    sx = SUMW'(p0x_q) + SUMW'(px_q >>> FRAC_BITS);
    sy = SUMW'(p0y_q) + SUMW'(py_q >>> FRAC_BITS);
    cx = hit_q ? sat(sx) : '0;
    cy = hit_q ? sat(sy) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      hit_o     <= hit_q;
      cross_x_o <= cx;
      cross_y_o <= cy;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/segment_segment_intersect.sv
// ----------------------------------------------------------------------------
// Segment segment intersection
// Pipelined 2D intersection test of two fixed-point segments.
// ----------------------------------------------------------------------------
// Input stream: one request per beat holding both segments (P0, P1, Q0, Q1),
// signed fixed point with FRAC_BITS fraction bits. Output stream: one result
// per request, in order: hit flag in tuser, intersection point in tdata
// (zero on a miss or for parallel segments).
// Throughput: one request per cycle unless the output stalls. The stages are
// four front stages, one divider cell per quotient bit (QB being
// max(FRAC_BITS,16)+2), then range/product and point stages.
// Every stage holds its own valid bit, so bubbles collapse and s_axis_tready
// stays high while any stage is free, even under output stall. A stalled
// output holds its beat until taken and backs the pipeline up stage by stage.
// Reset empties the pipeline and sets the tolerance register to 7; write the
// tolerance only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_segment_intersect import ssi_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [TOL_W-1:0]   cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  wire logic [255:0]       s_axis_tdata,
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // cross_x, cross_y
  output      logic [63:0]        m_axis_tdata,
  // hit
  output      logic               m_axis_tuser
);

  localparam int unsigned QB = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
  localparam int unsigned NW = CROSS_W + FRAC_BITS;

  logic [TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // divider chain links, index 0 is the front end output
  logic               c_valid [QB+1];
  logic               c_ready [QB+1];
  geo_t               c_geo   [QB+1];
  sign_t              c_sign  [QB+1];
  logic [CROSS_W-1:0] c_den   [QB+1];
  logic [NW-1:0]      c_rt    [QB+1];
  logic [NW-1:0]      c_ru    [QB+1];
  logic [QB-1:0]      c_qt    [QB+1];
  logic [QB-1:0]      c_qu    [QB+1];
  hs_t                front_hs;

  ssi_front #(
    .FRAC_BITS (FRAC_BITS),
    .QB        (QB),
    .NW        (NW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .coords_i (s_axis_tdata),
    .out_o    (front_hs),
    .ready_i  (c_ready[0]),
    .geo_o    (c_geo[0]),
    .sign_o   (c_sign[0]),
    .den_o    (c_den[0]),
    .num_t_o  (c_rt[0]),
    .num_u_o  (c_ru[0])
  );

  assign c_valid[0] = front_hs.valid;
  assign c_qt[0]    = '0;
  assign c_qu[0]    = '0;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    ssi_cell #(
      .QB  (QB),
      .NW  (NW),
      .BIT (QB - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[k]),
      .ready_o (c_ready[k]),
      .geo_i   (c_geo[k]),
      .sign_i  (c_sign[k]),
      .den_i   (c_den[k]),
      .rem_t_i (c_rt[k]),
      .rem_u_i (c_ru[k]),
      .q_t_i   (c_qt[k]),
      .q_u_i   (c_qu[k]),
      .valid_o (c_valid[k+1]),
      .ready_i (c_ready[k+1]),
      .geo_o   (c_geo[k+1]),
      .sign_o  (c_sign[k+1]),
      .den_o   (c_den[k+1]),
      .rem_t_o (c_rt[k+1]),
      .rem_u_o (c_ru[k+1]),
      .q_t_o   (c_qt[k+1]),
      .q_u_o   (c_qu[k+1])
    );
  end

  logic signed [COORD_W-1:0] cross_x, cross_y;

  ssi_back #(
    .FRAC_BITS (FRAC_BITS),
    .QB        (QB)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tol_i     (tol_q),
    .valid_i   (c_valid[QB]),
    .ready_o   (c_ready[QB]),
    .geo_i     (c_geo[QB]),
    .sign_i    (c_sign[QB]),
    .q_t_i     (c_qt[QB]),
    .q_u_i     (c_qu[QB]),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .hit_o     (m_axis_tuser),
    .cross_x_o (cross_x),
    .cross_y_o (cross_y)
  );

  assign m_axis_tdata = {cross_y, cross_x};

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss result carries a nonzero point");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> tol_q == $past(cfg_wdata_i))
    else $error("tolerance register not updated by write");

  a_tail_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> c_ready[QB])
    else $error("back end refuses data while output is empty");

  a_front_hs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !front_hs.valid |-> front_hs.ready)
    else $error("front end last stage empty but not ready");
`endif

endmodule

`default_nettype wire
